// ===== design/assert_macros.svh =====
// Assertion helpers shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every clock edge, reset included.
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/apr_pkg.sv =====
package apr_pkg;

  localparam int PAGE_W   = 27;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;
  localparam int QDEPTH   = 4;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ACCESS = 2'd1;
  localparam logic [MODE_W-1:0] MODE_VICTIM = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOMATCH = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd3;

  // Accessed flag value.
  localparam logic PTE_A = 1'b1;

  typedef enum logic [1:0] {OP_INSERT, OP_ACCESS, OP_VICTIM, OP_NOP} op_t;

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_SHIFT} state_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [PAGE_W-1:0] page_number;
  } req_t;

  typedef struct packed {
    logic [PAGE_W-1:0]   victim_page;
    logic [STATUS_W-1:0] status;
  } rsp_t;

  typedef struct packed {
    op_t               op;
    logic [PAGE_W-1:0] page;
  } cmd_t;

endpackage

// ===== design/aging_page_replacement.sv =====
// Aging page-replacement table with queue-style ports on both sides. Requests
// (insert, access, victim) enter a 4-deep command queue, so push stays open
// while the table engine is busy or a result waits in the output register,
// until the queue is full. Insert, access and the unused mode are handled
// straight from the idle state. A victim request on a non-empty table walks
// the resident slots one per cycle through a single age/compare unit, aging
// each and tracking the largest counter (oldest slot on ties), then closes
// the gap and loads the result. Every request yields exactly one result.
module aging_page_replacement import apr_pkg::*; #(
  parameter int SLOTS        = 8,
  parameter int COUNTER_BITS = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  req_t request,
  output logic empty,
  input  logic pop,
  output rsp_t result
);

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  apr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .request   (request),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  apr_back #(
    .SLOTS        (SLOTS),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

// ===== design/apr_front.sv =====
`include "assert_macros.svh"

module apr_front import apr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  req_t request,
  output logic cmd_valid,
  output cmd_t cmd,
  input  logic cmd_pop
);

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  cmd_t             queue [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  cmd_t             entry;

  always_comb begin
    entry.page = request.page_number;
    unique case (request.mode)
      MODE_INSERT: entry.op = OP_INSERT;
      MODE_ACCESS: entry.op = OP_ACCESS;
      MODE_VICTIM: entry.op = OP_VICTIM;
      default:     entry.op = OP_NOP;
    endcase
  end

  assign full      = (count == CNT_W'(QDEPTH));
  assign do_push   = push && !full;
  assign cmd_valid = (count != '0);
  assign cmd       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (cmd_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + CNT_W'(do_push) - CNT_W'(cmd_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) queue[wr_ptr] <= entry;
  end

  `ASSERT_PROP(a_q_bound, count <= CNT_W'(QDEPTH), "command queue overfilled")
  `ASSERT_PROP(a_pop_nonempty, cmd_pop |-> count != '0, "pop from empty command queue")

endmodule

// ===== design/apr_back.sv =====
`include "assert_macros.svh"

module apr_back import apr_pkg::*; #(
  parameter int SLOTS        = 8,
  parameter int COUNTER_BITS = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_pop,
  output logic empty,
  input  logic pop,
  output rsp_t result
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int OCC_W = $clog2(SLOTS + 1);
  localparam logic [COUNTER_BITS-1:0] AGE_MAX = {COUNTER_BITS{1'b1}};

  logic [PAGE_W-1:0]       pages [SLOTS];
  logic [COUNTER_BITS-1:0] ages  [SLOTS];
  logic                    flags [SLOTS];

  state_t                  state, state_next;
  logic [OCC_W-1:0]        occ;
  logic                    res_valid;
  logic                    res_load;
  rsp_t                    res_data;
  logic                    res_free;

  logic [IDX_W-1:0]        walk;
  logic [IDX_W-1:0]        last;
  logic [IDX_W-1:0]        ins_idx;
  logic [IDX_W-1:0]        pick;
  logic [COUNTER_BITS-1:0] best;
  logic [PAGE_W-1:0]       pick_page;
  logic [COUNTER_BITS-1:0] aged;
  logic                    take;
  logic                    table_full;
  logic [SLOTS-1:0]        match;
  logic                    hit;

  assign res_free   = !res_valid || pop;
  assign table_full = (occ == OCC_W'(SLOTS));
  assign ins_idx    = IDX_W'(occ);
  assign last       = IDX_W'(occ - 1'b1);
  assign empty      = !res_valid;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      match[i] = (OCC_W'(i) < occ) && (pages[i] == cmd.page);
    end
  end
  assign hit = |match;

  // Aging step for the slot under the walk pointer.
  always_comb begin
    if (flags[walk]) begin
      aged = '0;
    end else if (ages[walk] == AGE_MAX) begin
      aged = AGE_MAX;
    end else begin
      aged = ages[walk] + 1'b1;
    end
  end
  assign take = (aged > best);

  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    res_load   = 1'b0;
    res_data   = '0;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid && res_free) begin
          cmd_pop = 1'b1;
          unique case (cmd.op)
            OP_INSERT: begin
              res_load        = 1'b1;
              res_data.status = table_full ? STATUS_FULL : STATUS_OK;
            end
            OP_ACCESS: begin
              res_load        = 1'b1;
              res_data.status = hit ? STATUS_OK : STATUS_NOMATCH;
            end
            OP_VICTIM: begin
              if (occ == '0) begin
                res_load        = 1'b1;
                res_data.status = STATUS_EMPTY;
              end else begin
                state_next = S_WALK;
              end
            end
            default: begin
              res_load        = 1'b1;
              res_data.status = STATUS_OK;
            end
          endcase
        end
      end
      S_WALK: begin
        if (walk == last) state_next = S_SHIFT;
      end
      S_SHIFT: begin
        res_load             = 1'b1;
        res_data.victim_page = pick_page;
        res_data.status      = STATUS_OK;
        state_next           = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occ       <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd_pop && cmd.op == OP_INSERT && !table_full) begin
        occ <= occ + 1'b1;
      end else if (state == S_SHIFT) begin
        occ <= occ - 1'b1;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) result <= res_data;

    if (cmd_pop) begin
      if (cmd.op == OP_INSERT && !table_full) begin
        pages[ins_idx] <= cmd.page;
        ages[ins_idx]  <= '0;
        flags[ins_idx] <= 1'b0;
      end
      if (cmd.op == OP_ACCESS) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (match[i]) flags[i] <= PTE_A;
        end
      end
      walk      <= '0;
      best      <= '0;
      pick      <= '0;
      pick_page <= pages[0];
    end

    if (state == S_WALK) begin
      ages[walk]  <= aged;
      flags[walk] <= 1'b0;
      // Strictly greater keeps the oldest slot on ties.
      if (take) begin
        best      <= aged;
        pick      <= walk;
        pick_page <= pages[walk];
      end
      walk <= walk + 1'b1;
    end

    // Close the gap left by the victim.
    if (state == S_SHIFT) begin
      for (int j = 0; j < SLOTS - 1; j++) begin
        if (IDX_W'(j) >= pick) begin
          pages[j] <= pages[j+1];
          ages[j]  <= ages[j+1];
          flags[j] <= flags[j+1];
        end
      end
    end
  end

  `ASSERT_PROP(a_occ_bound, occ <= OCC_W'(SLOTS), "occupancy above slot count")
  `ASSERT_PROP(a_busy_no_result, state != S_IDLE |-> !res_valid, "result held during walk")
  `ASSERT_PROP(a_walk_range, state == S_WALK |-> walk <= last && occ != '0, "walk out of range")
  `ASSERT_RST(a_reset_idle, rst |=> state == S_IDLE && !res_valid && occ == '0, "bad reset")

endmodule

// ===== tb/tb_aging_page_replacement.sv =====
`timescale 1ns / 100ps

module tb_aging_page_replacement;
  import apr_pkg::*;

  localparam int SLOTS        = 8;
  localparam int COUNTER_BITS = 8;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int POOL_SIZE    = 16;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full;
  logic empty;
  req_t request = '0;
  rsp_t result;

  // Predicted table contents, oldest entry first.
  logic [PAGE_W-1:0]       resident_page [SLOTS];
  logic [COUNTER_BITS-1:0] resident_age  [SLOTS];
  logic                    resident_ref  [SLOTS];
  int                      resident_count = 0;

  rsp_t pending_results [$];
  rsp_t oldest_result;
  logic [PAGE_W-1:0] page_pool [POOL_SIZE];

  int mismatch_count = 0;
  int cycle_count    = 0;
  int burst_left     = 0;
  logic long_hold_req = 1'b0;
  int hold_left    = 0;
  int stretch_left = 0;
  int stall_style  = 0;

  aging_page_replacement #(
    .SLOTS        (SLOTS),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .request (request),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic rsp_t predict_replacement(req_t r);
    rsp_t                    rsp;
    int                      pick;
    logic [COUNTER_BITS-1:0] best;
    logic                    hit;
    rsp  = '0;
    rsp.status = STATUS_OK;
    pick = 0;
    best = '0;
    hit  = 1'b0;
    case (r.mode)
      MODE_INSERT: begin
        if (resident_count >= SLOTS) begin
          rsp.status = STATUS_FULL;
        end else begin
          resident_page[resident_count] = r.page_number;
          resident_age[resident_count]  = '0;
          resident_ref[resident_count]  = 1'b0;
          resident_count++;
        end
      end
      MODE_ACCESS: begin
        for (int i = 0; i < resident_count; i++) begin
          if (resident_page[i] == r.page_number) begin
            resident_ref[i] = PTE_A;
            hit = 1'b1;
          end
        end
        if (!hit) rsp.status = STATUS_NOMATCH;
      end
      MODE_VICTIM: begin
        if (resident_count == 0) begin
          rsp.status = STATUS_EMPTY;
        end else begin
          for (int i = 0; i < resident_count; i++) begin
            if (resident_ref[i] == PTE_A) begin
              resident_age[i] = '0;
              resident_ref[i] = 1'b0;
            end else if (resident_age[i] != {COUNTER_BITS{1'b1}}) begin
              resident_age[i]++;
            end
          end
          // Strictly greater keeps the oldest entry on ties.
          for (int i = 0; i < resident_count; i++) begin
            if (resident_age[i] > best) begin
              best = resident_age[i];
              pick = i;
            end
          end
          rsp.victim_page = resident_page[pick];
          for (int i = pick; i + 1 < resident_count; i++) begin
            resident_page[i] = resident_page[i + 1];
            resident_age[i]  = resident_age[i + 1];
            resident_ref[i]  = resident_ref[i + 1];
          end
          resident_count--;
        end
      end
      default: begin
      end
    endcase
    return rsp;
  endfunction

  // Result side: compare each popped transaction with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result victim_page=%h status=%0d", $time,
                 result.victim_page, result.status);
        mismatch_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (result.victim_page !== oldest_result.victim_page) begin
          $display("%0t: victim_page expected %h actual %h", $time,
                   oldest_result.victim_page, result.victim_page);
          mismatch_count++;
        end
        if (result.status !== oldest_result.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   oldest_result.status, result.status);
          mismatch_count++;
        end
      end
    end
  end

  // Receiver stall pattern, with an occasional long hold-off on request.
  always @(posedge clk) begin
    if (long_hold_req) begin
      hold_left     = LONG_HOLD;
      long_hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      if (stretch_left == 0) begin
        stall_style  = $urandom_range(0, 3);
        stretch_left = $urandom_range(5, 40);
      end
      stretch_left--;
      case (stall_style)
        0: pop <= 1'b1;
        1: pop <= ($urandom_range(0, 1) == 1);
        2: pop <= ($urandom_range(0, 4) == 0);
        default: pop <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  task automatic send_request(input logic [MODE_W-1:0] mode,
                              input logic [PAGE_W-1:0] page);
    req_t r;
    int   gap;
    r.mode        = mode;
    r.page_number = page;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    push    <= 1'b1;
    request <= r;
    @(posedge clk);
    while (full) @(posedge clk);
    pending_results.push_back(predict_replacement(r));
  endtask

  task automatic wait_results_done();
    push <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_cases();
    send_request(MODE_VICTIM, PAGE_W'(0));
    send_request(MODE_ACCESS, PAGE_W'(0));
    send_request(OP_NOP, {PAGE_W{1'b1}});
    send_request(MODE_INSERT, PAGE_W'(0));
    send_request(MODE_INSERT, {PAGE_W{1'b1}});
    // duplicate page is appended like any other
    send_request(MODE_INSERT, {PAGE_W{1'b1}});
    send_request(MODE_INSERT, PAGE_W'(27'h5555555));
    send_request(MODE_INSERT, PAGE_W'(27'h2AAAAAA));
    repeat (3) send_request(MODE_INSERT, PAGE_W'($urandom));
    send_request(MODE_INSERT, PAGE_W'(27'h0F0F0F0));
    send_request(MODE_INSERT, PAGE_W'(27'h0000123));
    // flag both copies of the duplicate
    send_request(MODE_ACCESS, {PAGE_W{1'b1}});
    send_request(MODE_ACCESS, PAGE_W'(27'h1234567));
    send_request(MODE_VICTIM, PAGE_W'($urandom));
    send_request(MODE_VICTIM, PAGE_W'(0));
    send_request(MODE_ACCESS, PAGE_W'(27'h5555555));
    send_request(MODE_VICTIM, PAGE_W'(0));
    send_request(OP_NOP, PAGE_W'(0));
    // drain to empty, then once more on the empty table
    repeat (6) send_request(MODE_VICTIM, PAGE_W'(0));
  endtask

  task automatic test_random_traffic(input int n_items);
    logic [MODE_W-1:0] mode;
    logic [PAGE_W-1:0] page;
    int                roll;
    int                ins_w;
    int                acc_w;
    int                vic_w;
    for (int n = 0; n < n_items; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        mode = OP_NOP;
        page = PAGE_W'($urandom);
      end else if (roll < 6) begin
        // noise: any valid mode with a page from anywhere
        mode = MODE_W'($urandom_range(0, 2));
        page = PAGE_W'($urandom);
      end else begin
        ins_w = (resident_count >= SLOTS) ? 4 : (SLOTS - resident_count) * 6;
        acc_w = 35;
        vic_w = resident_count * 6 + 3;
        roll  = $urandom_range(0, ins_w + acc_w + vic_w - 1);
        if (roll < ins_w) begin
          mode = MODE_INSERT;
          page = ($urandom_range(0, 9) < 7) ?
                 page_pool[$urandom_range(0, POOL_SIZE - 1)] : PAGE_W'($urandom);
        end else if (roll < ins_w + acc_w) begin
          mode = MODE_ACCESS;
          roll = $urandom_range(0, 9);
          if (roll < 7 && resident_count > 0)
            page = resident_page[$urandom_range(0, resident_count - 1)];
          else if (roll < 9)
            page = page_pool[$urandom_range(0, POOL_SIZE - 1)];
          else
            page = PAGE_W'($urandom);
        end else begin
          mode = MODE_VICTIM;
          page = PAGE_W'($urandom);
        end
      end
      send_request(mode, page);
    end
  endtask

  // Hold off the receiver while the sender keeps offering, so push stalls.
  task automatic test_stall_recovery();
    long_hold_req = 1'b1;
    burst_left    = 100;
    test_random_traffic(60);
  endtask

  initial begin
    page_pool[0] = '0;
    page_pool[1] = {PAGE_W{1'b1}};
    for (int i = 2; i < POOL_SIZE; i++) page_pool[i] = PAGE_W'($urandom);
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    wait_results_done();
    test_random_traffic(700);
    wait_results_done();
    test_stall_recovery();
    test_random_traffic(860);

    wait_results_done();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
